### sv/cascaded_motor_current_controller_defines.svh
// Assertion macros shared by the controller RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef CASCADED_MOTOR_CURRENT_CONTROLLER_DEFINES_SVH
`define CASCADED_MOTOR_CURRENT_CONTROLLER_DEFINES_SVH
`ifndef SYNTHESIS
`define CMCC_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("cmcc check failed");
`define CMCC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("cmcc check failed");
`else
`define CMCC_ASSERT_SAME(lbl, ante, cons)
`define CMCC_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

### sv/cmcc_pkg.sv
// Constants and helpers for the cascaded motor current controller.
// No dependencies.
`default_nettype none
package cmcc_pkg;

  // register indexes (byte address = 4 * index)
  localparam logic [2:0] REG_NEUTRAL  = 3'd0;
  localparam logic [2:0] REG_KP_POS   = 3'd1;
  localparam logic [2:0] REG_KI_POS   = 3'd2;
  localparam logic [2:0] REG_KP_SPEED = 3'd3;
  localparam logic [2:0] REG_KI_SPEED = 3'd4;
  localparam logic [2:0] REG_KD_SPEED = 3'd5;
  localparam logic [2:0] REG_KP_MODEL = 3'd6;
  localparam logic [2:0] REG_KD_MODEL = 3'd7;

  // filter coefficients, Q0.16
  localparam logic signed [16:0] PF_B = 17'sd3121;
  localparam logic signed [16:0] PF_A = 17'sd59294;
  localparam logic signed [16:0] PM_B = 17'sd5571;
  localparam logic signed [16:0] PM_A = 17'sd62259;

  localparam logic signed [31:0] I_LIMIT = 32'sd4194304;

  typedef logic signed [51:0] acc_t;
  typedef logic signed [31:0] q24_t;

  function automatic q24_t sat32(input acc_t x);
    if (x > 52'sd2147483647) return 32'sh7fffffff;
    if (x < -52'sd2147483648) return 32'sh80000000;
    return x[31:0];
  endfunction

  // round to nearest, halves toward +inf
  function automatic acc_t rnd(input acc_t x, input int s);
    acc_t h;
    h = 52'sd1 <<< (s - 1);
    return (x + h) >>> s;
  endfunction

  // Q24.8 to integer, truncated toward zero; magnitude kept unsigned so
  // the most negative value does not flip sign
  function automatic q24_t trunc8(input q24_t x);
    logic [31:0] m;
    m = -x;
    if (x >= 0) return x >>> 8;
    return -q24_t'(m >> 8);
  endfunction

endpackage
`default_nettype wire

### sv/cascaded_motor_current_controller.sv
// Cascaded position/speed PID with plant model error compensation.
// Depends on cmcc_pkg and cascaded_motor_current_controller_defines.svh.
//
//  channel  | handshake              | payload
//  ---------+------------------------+-------------------------------------------
//  in       | in_valid_i/in_ready_o  | req_type, encoder_angle, measured_speed,
//           |                        | target_value
//  out      | out_valid_o/out_ready_i| motor_current, unwrapped_position,
//           |                        | model_speed
//  cfg      | APB psel/penable/...   | 8 registers at 4*index, pready tied high
//
// From accept to result, the sequencer walks the chain through one shared
// 17x33 multiplier with a registered product; position mode runs the
// position loop states before the speed loop, speed mode skips them.
// in_ready_o is high only while the sequencer idles; a finished result is
// parked in the output register, and the sequencer stalls in its last step
// only when that register is still occupied.
// Reset (async, active low) clears all loop state and loads gain defaults.
`default_nettype none
`include "cascaded_motor_current_controller_defines.svh"
module cascaded_motor_current_controller #(
  parameter int ENCODER_COUNTS      = 8192,
  parameter int CURRENT_PER_RPM_Q12 = 4096,
  parameter int POS_KD_Q12          = 0
) (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                in_valid_i,
  output logic               in_ready_o,
  input  wire                req_type_i,
  input  wire         [12:0] encoder_angle_i,
  input  wire  signed [15:0] measured_speed_i,
  input  wire  signed [31:0] target_value_i,
  output logic               out_valid_o,
  input  wire                out_ready_i,
  output logic signed [15:0] motor_current_o,
  output logic signed [31:0] unwrapped_position_o,
  output logic signed [15:0] model_speed_o,
  input  wire                psel,
  input  wire                penable,
  input  wire                pwrite,
  input  wire         [4:0]  paddr,
  input  wire         [31:0] pwdata,
  output logic        [31:0] prdata,
  output logic               pready
);

  localparam logic signed [18:0] CNT_S  = 19'(ENCODER_COUNTS);
  localparam logic signed [18:0] HALF_S = 19'(ENCODER_COUNTS / 2);
  localparam logic signed [16:0] CUR_K  = 17'(CURRENT_PER_RPM_Q12);
  localparam logic signed [16:0] PKD_K  = 17'(POS_KD_Q12);

  typedef enum logic [4:0] {
    ST_IDLE, ST_PERR, ST_PI_M, ST_PI_A, ST_PP_A, ST_PD_A, ST_SPDT,
    ST_PF1, ST_PF2, ST_PF3, ST_SE, ST_SI_M, ST_SI_A, ST_SP_A, ST_SD_A,
    ST_CUR_M, ST_CUR_A, ST_PM1, ST_PM2, ST_PM3, ST_ME, ST_MP_M, ST_MP_A,
    ST_MD_A, ST_OUT
  } state_e;

  state_e state_q;

  // config registers
  logic [12:0] neutral_q;
  logic signed [15:0] kp_pos_q, ki_pos_q, kp_spd_q, ki_spd_q, kd_spd_q, kp_mod_q, kd_mod_q;
  logic cfg_wr;
  logic [2:0] cfg_idx;

  // loop state
  logic first_q;
  logic [12:0] last_angle_q;
  cmcc_pkg::q24_t pos_q, pint_q, pe_prev_q, pf_in_q, pf_out_q, sint_q, se_prev_q;
  cmcc_pkg::q24_t m_cur_q, m_out_q, me_prev_q;

  // per-beat working registers
  logic signed [23:0] meas_q;
  logic signed [31:0] target_q;
  cmcc_pkg::q24_t e_q, ts_q, f_q, se_q, need_q, want_q, mv_q, me_q, cur_q;
  cmcc_pkg::acc_t acc_q;
  logic signed [49:0] prod_q;

  // shared multiplier operands
  logic signed [16:0] mul_a;
  logic signed [32:0] mul_b;
  cmcc_pkg::acc_t prod_x;

  // unwrap
  logic signed [18:0] diff;
  cmcc_pkg::q24_t pos_d;

  logic in_acc;

  assign pready     = 1'b1;
  assign cfg_wr     = psel && penable && pwrite;
  assign cfg_idx    = paddr[4:2];
  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign prod_x     = 52'(prod_q);

  always_comb begin
    case (cfg_idx)
      cmcc_pkg::REG_NEUTRAL:  prdata = {19'd0, neutral_q};
      cmcc_pkg::REG_KP_POS:   prdata = 32'(kp_pos_q);
      cmcc_pkg::REG_KI_POS:   prdata = 32'(ki_pos_q);
      cmcc_pkg::REG_KP_SPEED: prdata = 32'(kp_spd_q);
      cmcc_pkg::REG_KI_SPEED: prdata = 32'(ki_spd_q);
      cmcc_pkg::REG_KD_SPEED: prdata = 32'(kd_spd_q);
      cmcc_pkg::REG_KP_MODEL: prdata = 32'(kp_mod_q);
      cmcc_pkg::REG_KD_MODEL: prdata = 32'(kd_mod_q);
      default:                prdata = 32'd0;
    endcase
  end

  // angle unwrap, one step wrapped once by the encoder span
  always_comb begin
    if (first_q) begin
      diff = signed'({6'd0, encoder_angle_i}) - signed'({6'd0, neutral_q});
    end else begin
      diff = signed'({6'd0, encoder_angle_i}) - signed'({6'd0, last_angle_q});
    end
    if (diff > HALF_S) begin
      diff = diff - CNT_S;
    end else if (diff < -HALF_S) begin
      diff = diff + CNT_S;
    end
    if (first_q) begin
      pos_d = cmcc_pkg::sat32(52'(diff));
    end else begin
      pos_d = cmcc_pkg::sat32(52'(pos_q) + 52'(diff));
    end
  end

  // operand select for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      ST_PI_M: begin
        mul_a = 17'(ki_pos_q);
        mul_b = 33'(e_q) + 33'(pe_prev_q);
      end
      ST_PI_A: begin
        mul_a = 17'(kp_pos_q);
        mul_b = 33'(e_q);
      end
      ST_PP_A: begin
        mul_a = PKD_K;
        mul_b = 33'(e_q) - 33'(pe_prev_q);
      end
      ST_PF1: begin
        mul_a = cmcc_pkg::PF_B;
        mul_b = 33'(ts_q) + 33'(pf_in_q);
      end
      ST_PF2: begin
        mul_a = cmcc_pkg::PF_A;
        mul_b = 33'(pf_out_q);
      end
      ST_SI_M: begin
        mul_a = 17'(ki_spd_q);
        mul_b = 33'(se_q) + 33'(se_prev_q);
      end
      ST_SI_A: begin
        mul_a = 17'(kp_spd_q);
        mul_b = 33'(se_q);
      end
      ST_SP_A: begin
        mul_a = 17'(kd_spd_q);
        mul_b = 33'(se_q) - 33'(se_prev_q);
      end
      ST_CUR_M: begin
        mul_a = CUR_K;
        mul_b = 33'(need_q);
      end
      ST_PM1: begin
        mul_a = cmcc_pkg::PM_B;
        mul_b = 33'(want_q) + 33'(m_cur_q);
      end
      ST_PM2: begin
        mul_a = cmcc_pkg::PM_A;
        mul_b = 33'(m_out_q);
      end
      ST_MP_M: begin
        mul_a = 17'(kp_mod_q);
        mul_b = 33'(me_q);
      end
      ST_MP_A: begin
        mul_a = 17'(kd_mod_q);
        mul_b = 33'(me_q) - 33'(me_prev_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // output formatting
  cmcc_pkg::q24_t cur_clamp, cur_int, ms_int;
  logic signed [15:0] ms_sat;
  always_comb begin
    cur_clamp = cur_q;
    if (cur_q > cmcc_pkg::I_LIMIT) cur_clamp = cmcc_pkg::I_LIMIT;
    if (cur_q < -cmcc_pkg::I_LIMIT) cur_clamp = -cmcc_pkg::I_LIMIT;
    cur_int = cmcc_pkg::trunc8(cur_clamp);
    ms_int  = cmcc_pkg::trunc8(mv_q);
    if (ms_int > 32'sd32767) begin
      ms_sat = 16'sh7fff;
    end else if (ms_int < -32'sd32768) begin
      ms_sat = 16'sh8000;
    end else begin
      ms_sat = ms_int[15:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      neutral_q <= '0;
      kp_pos_q  <= 16'sd205;
      ki_pos_q  <= '0;
      kp_spd_q  <= 16'sd4096;
      ki_spd_q  <= '0;
      kd_spd_q  <= '0;
      kp_mod_q  <= 16'sd26624;
      kd_mod_q  <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        cmcc_pkg::REG_NEUTRAL:  neutral_q <= pwdata[12:0];
        cmcc_pkg::REG_KP_POS:   kp_pos_q  <= pwdata[15:0];
        cmcc_pkg::REG_KI_POS:   ki_pos_q  <= pwdata[15:0];
        cmcc_pkg::REG_KP_SPEED: kp_spd_q  <= pwdata[15:0];
        cmcc_pkg::REG_KI_SPEED: ki_spd_q  <= pwdata[15:0];
        cmcc_pkg::REG_KD_SPEED: kd_spd_q  <= pwdata[15:0];
        cmcc_pkg::REG_KP_MODEL: kp_mod_q  <= pwdata[15:0];
        cmcc_pkg::REG_KD_MODEL: kd_mod_q  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // payload scratch, no reset needed
  always_ff @(posedge clk_i) begin
    prod_q <= 50'(mul_a) * 50'(mul_b);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      out_valid_o  <= 1'b0;
      first_q      <= 1'b1;
      last_angle_q <= '0;
      pos_q        <= '0;
      pint_q       <= '0;
      pe_prev_q    <= '0;
      pf_in_q      <= '0;
      pf_out_q     <= '0;
      sint_q       <= '0;
      se_prev_q    <= '0;
      m_cur_q      <= '0;
      m_out_q      <= '0;
      me_prev_q    <= '0;
      meas_q       <= '0;
      target_q     <= '0;
      e_q <= '0; ts_q <= '0; f_q <= '0; se_q <= '0; need_q <= '0;
      want_q <= '0; mv_q <= '0; me_q <= '0; cur_q <= '0; acc_q <= '0;
      motor_current_o      <= '0;
      unwrapped_position_o <= '0;
      model_speed_o        <= '0;
    end else begin
      // ST_OUT handles its own handoff of the output register
      if (out_valid_o && out_ready_i && state_q != ST_OUT) out_valid_o <= 1'b0;
      if (cfg_wr && cfg_idx == cmcc_pkg::REG_NEUTRAL && !in_acc) first_q <= 1'b1;
      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            first_q      <= 1'b0;
            last_angle_q <= encoder_angle_i;
            pos_q        <= pos_d;
            meas_q       <= 24'(measured_speed_i) <<< 8;
            target_q     <= target_value_i;
            state_q      <= req_type_i ? ST_PERR : ST_SPDT;
          end
        end
        ST_PERR: begin
          e_q     <= cmcc_pkg::sat32((52'(target_q) - 52'(pos_q)) <<< 8);
          state_q <= ST_PI_M;
        end
        ST_PI_M: state_q <= ST_PI_A;
        ST_PI_A: begin
          pint_q  <= cmcc_pkg::sat32(52'(pint_q) + cmcc_pkg::rnd(prod_x, 13));
          state_q <= ST_PP_A;
        end
        ST_PP_A: begin
          acc_q   <= cmcc_pkg::rnd(prod_x, 12) + 52'(pint_q);
          state_q <= ST_PD_A;
        end
        ST_PD_A: begin
          ts_q      <= cmcc_pkg::sat32(acc_q + cmcc_pkg::rnd(prod_x, 12));
          pe_prev_q <= e_q;
          state_q   <= ST_PF1;
        end
        ST_SPDT: begin
          ts_q    <= cmcc_pkg::sat32(52'(target_q) <<< 8);
          state_q <= ST_PF1;
        end
        ST_PF1: state_q <= ST_PF2;
        ST_PF2: begin
          acc_q   <= prod_x;
          state_q <= ST_PF3;
        end
        ST_PF3: begin
          f_q      <= cmcc_pkg::sat32(cmcc_pkg::rnd(acc_q + prod_x, 16));
          pf_out_q <= cmcc_pkg::sat32(cmcc_pkg::rnd(acc_q + prod_x, 16));
          pf_in_q  <= ts_q;
          state_q  <= ST_SE;
        end
        ST_SE: begin
          se_q    <= cmcc_pkg::sat32(52'(f_q) - 52'(meas_q));
          state_q <= ST_SI_M;
        end
        ST_SI_M: state_q <= ST_SI_A;
        ST_SI_A: begin
          sint_q  <= cmcc_pkg::sat32(52'(sint_q) + cmcc_pkg::rnd(prod_x, 13));
          state_q <= ST_SP_A;
        end
        ST_SP_A: begin
          acc_q   <= 52'(f_q) + cmcc_pkg::rnd(prod_x, 12) + 52'(sint_q);
          state_q <= ST_SD_A;
        end
        ST_SD_A: begin
          need_q    <= cmcc_pkg::sat32(acc_q + cmcc_pkg::rnd(prod_x, 12));
          se_prev_q <= se_q;
          state_q   <= ST_CUR_M;
        end
        ST_CUR_M: state_q <= ST_CUR_A;
        ST_CUR_A: begin
          want_q  <= cmcc_pkg::sat32(cmcc_pkg::rnd(prod_x, 12));
          state_q <= ST_PM1;
        end
        ST_PM1: state_q <= ST_PM2;
        ST_PM2: begin
          acc_q   <= prod_x;
          state_q <= ST_PM3;
        end
        ST_PM3: begin
          mv_q    <= cmcc_pkg::sat32(cmcc_pkg::rnd(acc_q + prod_x, 16));
          m_out_q <= cmcc_pkg::sat32(cmcc_pkg::rnd(acc_q + prod_x, 16));
          m_cur_q <= want_q;
          state_q <= ST_ME;
        end
        ST_ME: begin
          me_q    <= cmcc_pkg::sat32(52'(mv_q) - 52'(meas_q));
          state_q <= ST_MP_M;
        end
        ST_MP_M: state_q <= ST_MP_A;
        ST_MP_A: begin
          acc_q   <= 52'(want_q) + cmcc_pkg::rnd(prod_x, 12);
          state_q <= ST_MD_A;
        end
        ST_MD_A: begin
          cur_q     <= cmcc_pkg::sat32(acc_q + cmcc_pkg::rnd(prod_x, 12));
          me_prev_q <= me_q;
          state_q   <= ST_OUT;
        end
        ST_OUT: begin
          // park the beat once the output register is free
          if (!out_valid_o || out_ready_i) begin
            out_valid_o          <= 1'b1;
            motor_current_o      <= cur_int[15:0];
            unwrapped_position_o <= pos_q;
            model_speed_o        <= ms_sat;
            state_q              <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  `CMCC_ASSERT_NEXT(a_busy_after_accept, in_acc, !in_ready_o)
  `CMCC_ASSERT_NEXT(a_pos_path, in_acc && req_type_i, state_q == ST_PERR)
  `CMCC_ASSERT_SAME(a_cur_range, out_valid_o, motor_current_o <= 16'sd16384 && motor_current_o >= -16'sd16384)
  `CMCC_ASSERT_NEXT(a_first_cleared, in_acc && !(cfg_wr && cfg_idx == cmcc_pkg::REG_NEUTRAL), !first_q)

endmodule
`default_nettype wire
